>>> hdl/ftmr_pkg.sv
// Shared constants and types for the fan tach measure and regenerate block.
package ftmr_pkg;

    // Default widths of the tach timer and pulse counter
    localparam int unsigned DEF_TIMER_BITS       = 16;
    localparam int unsigned DEF_PULSE_COUNT_BITS = 16;

    // Fixed field widths
    localparam int unsigned CFG_DATA_BITS  = 16;
    localparam int unsigned CFG_INDEX_BITS = 8;
    localparam int unsigned TOP_BITS       = 16;
    localparam int unsigned RPM_BITS       = 21;
    localparam int unsigned IN_DATA_BITS   = 8;
    localparam int unsigned OUT_DATA_BITS  = 40;
    localparam int unsigned OUT_USER_BITS  = 1;

    // Reset values and limits
    localparam logic [CFG_DATA_BITS-1:0] WINDOW_TICKS_RESET = 16'd15625;
    localparam logic [CFG_DATA_BITS-1:0] TIMER_RATE_RESET   = 16'd15625;
    localparam logic [TOP_BITS-1:0]      TOP_RESET          = 16'd15624;
    localparam logic [TOP_BITS-1:0]      TOP_IDLE_FAN       = 16'hFFFF;
    localparam logic [RPM_BITS-1:0]      RPM_MAX            = 21'd1966020;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_TICKS = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TIMER_RATE   = 8'd1;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } t_state;

endpackage

>>> hdl/ftmr_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module ftmr_div
    import ftmr_pkg::*;
#(
    parameter int unsigned DIVISOR_BITS = DEF_PULSE_COUNT_BITS + 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [TOP_BITS-1:0]     i_dividend,
    input  logic [DIVISOR_BITS-1:0] i_divisor,
    output logic                    o_done,
    output logic [TOP_BITS-1:0]     o_quot
);

    localparam int unsigned CNT_BITS = $clog2(TOP_BITS);

    logic                    r_busy;
    logic                    r_done;
    logic [CNT_BITS-1:0]     r_cnt;
    logic [DIVISOR_BITS-1:0] r_rem;
    logic [DIVISOR_BITS-1:0] r_div;
    logic [TOP_BITS-1:0]     r_quot;

    logic [DIVISOR_BITS:0]   w_shift;
    logic [DIVISOR_BITS:0]   w_diff;
    logic                    w_ge;

    // Shift in the next dividend bit and trial-subtract the divisor
    always_comb begin
        w_shift = {r_rem, r_quot[TOP_BITS-1]};
        w_ge    = (w_shift >= {1'b0, r_div});
        w_diff  = w_shift - {1'b0, r_div};
    end

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CNT_BITS'(TOP_BITS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(TOP_BITS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_quot <= i_dividend;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[DIVISOR_BITS-1:0] : w_shift[DIVISOR_BITS-1:0];
            r_quot <= {r_quot[TOP_BITS-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start)
        else $error("divider restarted while busy");
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !$past(i_start) |-> r_rem < r_div)
        else $error("divider remainder not below divisor");
`endif

endmodule

>>> hdl/fan_tach_measure_and_regenerate_top.sv
// Fan tach measurement and square-wave regeneration, top level.
//
// Each input transfer is one sample cycle: tdata[0] is the sampled tach level and tdata[1]
// the prescaled timer tick. Rising tach edges are counted; after window_ticks ticks the
// window closes, the rpm is latched and a new compare top (timer_rate / (4 * half count) - 1)
// is loaded into the output timer, which toggles tach_out on each match. Every input
// transfer yields exactly one output transfer. A sample that does not close a window, or
// closes one with fewer than two pulses counted, needs no division. A sample that closes a
// window with two or more pulses starts a bit-serial divider on its accepting edge; the
// divider resolves one of its 16 quotient bits per cycle, then the compare top is loaded and
// the result presented. The block takes no input while the divider runs. Configuration
// writes are always accepted.
module fan_tach_measure_and_regenerate_top
    import ftmr_pkg::*;
#(
    parameter int unsigned TIMER_BITS       = DEF_TIMER_BITS,
    parameter int unsigned PULSE_COUNT_BITS = DEF_PULSE_COUNT_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input stream
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]   i_s_axis_tdata,  // [0] tach_in, [1] timer_tick, rest 0
    // output stream
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [OUT_DATA_BITS-1:0]  o_m_axis_tdata,  // [0] tach_out, [21:1] measured_rpm,
                                                       // [37:22] top_value, rest 0
    output logic [OUT_USER_BITS-1:0]  o_m_axis_tuser,  // [0] window_done
    // configuration write channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int unsigned HZ_BITS       = PULSE_COUNT_BITS + 1;
    localparam int unsigned RPM_CALC_BITS = PULSE_COUNT_BITS + 5;
    localparam int unsigned RPM_CMP_BITS  =
        (RPM_CALC_BITS > RPM_BITS) ? RPM_CALC_BITS : RPM_BITS;
    localparam int unsigned CMP_BITS      = (TIMER_BITS > TOP_BITS) ? TIMER_BITS : TOP_BITS;

    t_state                      r_state;
    t_state                      n_state;
    logic [CFG_DATA_BITS-1:0]    r_window_ticks;
    logic [CFG_DATA_BITS-1:0]    r_timer_rate;
    logic                        r_prev_tach;
    logic [PULSE_COUNT_BITS-1:0] r_pulse_count;
    logic [PULSE_COUNT_BITS-1:0] n_pulse_count;
    logic [CFG_DATA_BITS-1:0]    r_window_count;
    logic [TIMER_BITS-1:0]       r_timer_count;
    logic [TOP_BITS-1:0]         r_compare_top;
    logic                        r_out_level;
    logic [RPM_BITS-1:0]         r_last_rpm;
    logic                        r_out_valid;
    logic                        r_done;

    logic                        w_tach;
    logic                        w_tick;
    logic                        w_accept;
    logic                        w_close;
    logic                        w_match;
    logic [PULSE_COUNT_BITS-2:0] w_half;
    logic [HZ_BITS-1:0]          w_hz;
    logic [RPM_CALC_BITS-1:0]    w_rpm_full;
    logic [RPM_BITS-1:0]         w_rpm_sat;
    logic                        w_div_start;
    logic                        w_div_done;
    logic [TOP_BITS-1:0]         w_quot;
    logic [TOP_BITS-1:0]         w_new_top;

    assign w_tach   = i_s_axis_tdata[0];
    assign w_tick   = i_s_axis_tdata[1];
    assign w_accept = i_s_axis_tvalid & o_s_axis_tready;
    assign o_cfg_ready = 1'b1;

    // Count the tach edge, then derive window results from the updated count
    always_comb begin
        n_pulse_count = r_pulse_count;
        if (w_tach && !r_prev_tach && (r_pulse_count != '1)) begin
            n_pulse_count = r_pulse_count + 1'b1;
        end
        w_half     = n_pulse_count[PULSE_COUNT_BITS-1:1];
        w_hz       = {w_half, 2'b00};
        w_rpm_full = {w_half, 6'b000000} - RPM_CALC_BITS'({w_half, 2'b00});
        w_rpm_sat  = (RPM_CMP_BITS'(w_rpm_full) > RPM_CMP_BITS'(RPM_MAX)) ?
                     RPM_MAX : RPM_BITS'(w_rpm_full);
        w_close    = w_tick &&
                     (({1'b0, r_window_count} + 17'd1) >= {1'b0, r_window_ticks});
        w_match    = (CMP_BITS'(r_timer_count) == CMP_BITS'(r_compare_top));
        w_new_top  = (w_quot == '0) ? '0 : (w_quot - 1'b1);
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_div_start) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_div_start     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = !r_out_valid || i_m_axis_tready;
                w_div_start     = i_s_axis_tvalid && o_s_axis_tready && w_close &&
                                  (w_hz != '0);
            end
            ST_DIV: begin
                o_s_axis_tready = 1'b0;
                w_div_start     = 1'b0;
            end
            default: begin
                o_s_axis_tready = 1'b0;
                w_div_start     = 1'b0;
            end
        endcase
    end

    // Divider for the compare top
    ftmr_div #(
        .DIVISOR_BITS(HZ_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_timer_rate),
        .i_divisor  (w_hz),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // Hold state, config and measurement registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_window_ticks <= WINDOW_TICKS_RESET;
            r_timer_rate   <= TIMER_RATE_RESET;
            r_prev_tach    <= 1'b0;
            r_pulse_count  <= '0;
            r_window_count <= '0;
            r_timer_count  <= '0;
            r_compare_top  <= TOP_RESET;
            r_out_level    <= 1'b0;
            r_last_rpm     <= '0;
            r_out_valid    <= 1'b0;
            r_done         <= 1'b0;
        end else begin
            r_state <= n_state;

            // Take configuration writes; drop unknown indexes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_WINDOW_TICKS: r_window_ticks <= i_cfg_data;
                    CFG_TIMER_RATE:   r_timer_rate   <= i_cfg_data;
                    default: ;
                endcase
            end

            // Advance the sample cycle on an input transfer
            if (w_accept) begin
                r_prev_tach   <= w_tach;
                r_pulse_count <= w_close ? '0 : n_pulse_count;
                r_done        <= w_close;
                r_out_valid   <= !w_div_start;
                if (w_tick) begin
                    if (w_match) begin
                        r_out_level   <= ~r_out_level;
                        r_timer_count <= '0;
                    end else begin
                        r_timer_count <= r_timer_count + 1'b1;
                    end
                    if (w_close) begin
                        r_last_rpm     <= w_rpm_sat;
                        r_window_count <= '0;
                        if (w_hz == '0) begin
                            r_compare_top <= TOP_IDLE_FAN;
                        end
                    end else begin
                        r_window_count <= r_window_count + 1'b1;
                    end
                end
            end else if (w_div_done) begin
                r_compare_top <= w_new_top;
                r_out_valid   <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_compare_top, r_last_rpm, r_out_level};
    assign o_m_axis_tuser  = r_done;

`ifndef SYNTHESIS
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divider result outside the divide state");
    a_start_enters_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |=> (r_state == ST_DIV) && !r_out_valid)
        else $error("divide start did not enter the divide state");
    a_done_clears_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_done |-> (r_window_count == '0))
        else $error("window closed but window count not cleared");
    a_no_input_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> !o_s_axis_tready && !r_out_valid)
        else $error("input or output open while dividing");
`endif

endmodule

>>> sim/fan_tach_measure_and_regenerate_top_tb.sv
// Self-checking testbench for the fan tach measure and regenerate block.
module fan_tach_measure_and_regenerate_top_tb;
    import ftmr_pkg::*;

    localparam int unsigned RUN_LIMIT       = 2_000_000;
    localparam int unsigned DRAIN_CYCLES    = 24;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam logic [15:0] PULSE_FULL      = 16'hFFFF;

    // Register indexes the block does not decode
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LOW  = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HIGH = 8'hFF;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY
    } t_rx_mode;

    typedef struct packed {
        logic tach;
        logic tick;
    } t_fan_sample;

    typedef struct packed {
        logic                level;
        logic                done;
        logic [RPM_BITS-1:0] rpm;
        logic [TOP_BITS-1:0] top;
    } t_fan_reading;

    logic                      i_clk     = 1'b0;
    logic                      i_rst_n   = 1'b0;
    logic                      s_valid   = 1'b0;
    logic [IN_DATA_BITS-1:0]   s_data    = '0;
    logic                      s_ready;
    logic                      m_valid;
    logic                      m_ready   = 1'b0;
    logic [OUT_DATA_BITS-1:0]  m_data;
    logic [OUT_USER_BITS-1:0]  m_user;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    fan_tach_measure_and_regenerate_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // Stimulus and expectation stores
    t_fan_sample  sample_q[$];
    t_fan_reading pending_readings[$];
    int unsigned  fail_count  = 0;
    int unsigned  cycle_count = 0;
    bit           hold_armed  = 1'b0;
    bit           hold_done   = 1'b0;

    // Predictor copy of the registers and state
    logic [CFG_DATA_BITS-1:0] win_ticks_reg;
    logic [CFG_DATA_BITS-1:0] rate_reg;
    logic                     prev_tach_lvl;
    logic [15:0]              pulse_cnt;
    logic [15:0]              win_cnt;
    logic [15:0]              ctc_cnt;
    logic [TOP_BITS-1:0]      ctc_top;
    logic                     out_lvl;
    logic [RPM_BITS-1:0]      rpm_latched;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void reset_regen_model();
        win_ticks_reg = WINDOW_TICKS_RESET;
        rate_reg      = TIMER_RATE_RESET;
        prev_tach_lvl = 1'b0;
        pulse_cnt     = '0;
        win_cnt       = '0;
        ctc_cnt       = '0;
        ctc_top       = TOP_RESET;
        out_lvl       = 1'b0;
        rpm_latched   = '0;
    endfunction

    function automatic void write_regen_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                            input logic [CFG_DATA_BITS-1:0] val);
        if (idx == CFG_WINDOW_TICKS) begin
            win_ticks_reg = val;
        end else if (idx == CFG_TIMER_RATE) begin
            rate_reg = val;
        end
    endfunction

    // New compare top from half the pulse count: rate / (4 * half) - 1, idle fan gives max
    function automatic logic [TOP_BITS-1:0] top_for_half(input logic [15:0] half);
        int unsigned hz;
        int unsigned quot;
        hz = 4 * half;
        if (hz == 0) begin
            return TOP_IDLE_FAN;
        end
        quot = rate_reg / hz;
        if (quot == 0) begin
            return '0;
        end
        quot = quot - 1;
        return (quot > TOP_IDLE_FAN) ? TOP_IDLE_FAN : quot[TOP_BITS-1:0];
    endfunction

    // Advance the tach model by one sample and return the reading it produces
    function automatic t_fan_reading tach_regen_step(input t_fan_sample smp);
        t_fan_reading res;
        logic [15:0]  half;
        int unsigned  rpm;
        int unsigned  win_next;
        res.done = 1'b0;
        if (smp.tach && !prev_tach_lvl && pulse_cnt != PULSE_FULL) begin
            pulse_cnt = pulse_cnt + 1'b1;
        end
        prev_tach_lvl = smp.tach;
        if (smp.tick) begin
            // Output timer steps against the old top before a window may reload it
            if (ctc_cnt == ctc_top) begin
                out_lvl = ~out_lvl;
                ctc_cnt = '0;
            end else begin
                ctc_cnt = ctc_cnt + 1'b1;
            end
            win_next = win_cnt + 1;
            if (win_next >= win_ticks_reg) begin
                half        = pulse_cnt >> 1;
                rpm         = half * 60;
                rpm_latched = (rpm > RPM_MAX) ? RPM_MAX : rpm[RPM_BITS-1:0];
                ctc_top     = top_for_half(half);
                pulse_cnt   = '0;
                win_cnt     = '0;
                res.done    = 1'b1;
            end else begin
                win_cnt = win_next[15:0];
            end
        end
        res.level = out_lvl;
        res.rpm   = rpm_latched;
        res.top   = ctc_top;
        return res;
    endfunction

    function automatic void check_field(input string tag, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, tag, exp_val, act_val);
        end
    endfunction

    // Sample driver: bursts of transfers with random gaps between them
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    always @(posedge i_clk) begin
        t_fan_sample nxt;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left != 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (sample_q.size() != 0) begin
                nxt = sample_q.pop_front();
                s_data  <= IN_DATA_BITS'({nxt.tick, nxt.tach});
                s_valid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Reading receiver: its own stall pattern, plus one long hold-off to back up the block
    t_rx_mode    ready_mode = RX_OPEN;
    int unsigned mode_left  = 0;
    int unsigned hold_left  = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = t_rx_mode'($urandom_range(0, 2));
                mode_left  = $urandom_range(8, 64);
            end else begin
                mode_left--;
            end
            if (ready_mode == RX_OPEN) begin
                m_ready <= 1'b1;
            end else if (ready_mode == RX_LIGHT) begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end else begin
                m_ready <= ($urandom_range(0, 2) == 0);
            end
        end
    end

    // Monitor: predict on each accepted sample, then check each accepted reading
    always @(posedge i_clk) begin
        t_fan_sample  smp;
        t_fan_reading want;
        if (i_rst_n) begin
            if (s_valid && s_ready) begin
                smp.tach = s_data[0];
                smp.tick = s_data[1];
                pending_readings.push_back(tach_regen_step(smp));
            end
            if (m_valid && m_ready) begin
                if (pending_readings.size() == 0) begin
                    fail_count++;
                    $display("%0t: reading transfer with nothing pending, got data %h user %h",
                             $time, m_data, m_user);
                end else begin
                    want = pending_readings.pop_front();
                    check_field("tach_out", want.level, m_data[0]);
                    check_field("window_done", want.done, m_user[0]);
                    check_field("measured_rpm", want.rpm, m_data[RPM_BITS:1]);
                    check_field("top_value", want.top, m_data[RPM_BITS+TOP_BITS:RPM_BITS+1]);
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    task automatic queue_sample(input logic tach, input logic tick);
        t_fan_sample smp;
        smp.tach = tach;
        smp.tick = tick;
        sample_q.push_back(smp);
    endtask

    // Wait until every queued sample is taken and every reading has come back
    task automatic settle();
        while (sample_q.size() != 0 || s_valid || pending_readings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        write_regen_reg(idx, val);
        @(posedge i_clk);
    endtask

    // Mostly clean square-wave tach runs with random ticks, some pure noise runs
    task automatic queue_random_runs(input int unsigned total);
        int unsigned left;
        int unsigned run_len;
        int unsigned half_per;
        int unsigned tick_pct;
        int unsigned k;
        logic        lvl;
        bit          noisy;
        left = total;
        while (left != 0) begin
            run_len  = $urandom_range(8, 30);
            if (run_len > left) begin
                run_len = left;
            end
            half_per = $urandom_range(1, 5);
            tick_pct = $urandom_range(15, 100);
            noisy    = ($urandom_range(0, 4) == 0);
            lvl      = 1'($urandom_range(0, 1));
            for (k = 0; k < run_len; k++) begin
                if (noisy) begin
                    lvl = 1'($urandom_range(0, 1));
                end else if (k % half_per == 0) begin
                    lvl = ~lvl;
                end
                queue_sample(lvl, $urandom_range(1, 100) <= tick_pct);
            end
            left -= run_len;
        end
    endtask

    task automatic random_phase(input logic [CFG_DATA_BITS-1:0] win,
                                input logic [CFG_DATA_BITS-1:0] rate,
                                input int unsigned total);
        write_reg(CFG_WINDOW_TICKS, win);
        write_reg(CFG_TIMER_RATE, rate);
        queue_random_runs(total);
        settle();
    endtask

    initial begin
        reset_regen_model();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: every tach and tick combination
        queue_sample(1'b0, 1'b0);
        queue_sample(1'b1, 1'b0);
        queue_sample(1'b0, 1'b1);
        queue_sample(1'b1, 1'b1);
        queue_sample(1'b1, 1'b1);
        queue_sample(1'b0, 1'b0);
        settle();

        // Zero window length and zero rate: close on every tick, empty and full windows
        write_reg(CFG_WINDOW_TICKS, 16'd0);
        write_reg(CFG_TIMER_RATE, 16'd0);
        queue_sample(1'b0, 1'b1);
        queue_sample(1'b1, 1'b0);
        queue_sample(1'b0, 1'b0);
        queue_sample(1'b1, 1'b1);
        queue_sample(1'b0, 1'b1);
        queue_sample(1'b1, 1'b1);
        settle();

        // Undecoded indexes must leave the registers alone
        write_reg(CFG_TIMER_RATE, 16'hFFFF);
        write_reg(CFG_SPARE_LOW, 16'd3);
        write_reg(CFG_SPARE_HIGH, 16'h5555);
        queue_sample(1'b1, 1'b0);
        queue_sample(1'b0, 1'b0);
        queue_sample(1'b1, 1'b1);
        queue_sample(1'b0, 1'b1);
        queue_sample(1'b0, 1'b1);
        settle();

        // Random phases across several settings; the first one carries the long hold-off
        write_reg(CFG_WINDOW_TICKS, 16'd2);
        write_reg(CFG_TIMER_RATE, 16'($urandom_range(1, 65535)));
        queue_random_runs(90);
        hold_armed = 1'b1;
        settle();
        random_phase(16'($urandom_range(3, 12)), 16'($urandom_range(1, 64)), 90);
        random_phase(16'd1, 16'd1, 60);
        random_phase(16'hFFFF, 16'hFFFF, 40);
        random_phase(16'($urandom_range(0, 8)), 16'd0, 60);
        random_phase(16'($urandom_range(1, 6)), 16'($urandom_range(100, 4000)), 100);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_readings.size() != 0) begin
            fail_count++;
            $display("%0t: %0d readings never arrived", $time, pending_readings.size());
        end
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> fan_tach_measure_and_regenerate_top.f
hdl/ftmr_pkg.sv
hdl/ftmr_div.sv
hdl/fan_tach_measure_and_regenerate_top.sv
sim/fan_tach_measure_and_regenerate_top_tb.sv
